@@ sv/tapsc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tapsc_pkg
// Shared types and constants of the two-axis PID servo controller: beat
// formats of both channels, register indexes, reset values and limits.
// ============================================================================
package tapsc_pkg;

    // One camera sample
    typedef struct packed {
        logic [7:0] ball_x;
        logic [7:0] ball_y;
    } t_in_beat;

    // One pair of servo compare values
    typedef struct packed {
        logic [10:0] pulse_x;
        logic [10:0] pulse_y;
        logic        target_lost;
    } t_out_beat;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_SETPOINT_X = 3'd0,
        REG_SETPOINT_Y = 3'd1,
        REG_GAIN_P_X   = 3'd2,
        REG_GAIN_D_X   = 3'd3,
        REG_GAIN_I_X   = 3'd4,
        REG_GAIN_P_Y   = 3'd5,
        REG_GAIN_D_Y   = 3'd6,
        REG_GAIN_I_Y   = 3'd7
    } t_reg_idx;

    localparam int unsigned GAIN_W = 24;
    localparam int unsigned CFG_W  = 24;

    // Register reset values
    localparam logic [7:0]        RST_SETPOINT_X = 8'd80;
    localparam logic [7:0]        RST_SETPOINT_Y = 8'd60;
    localparam logic [GAIN_W-1:0] RST_GAIN_P_X   = 24'd140902;
    localparam logic [GAIN_W-1:0] RST_GAIN_D_X   = 24'd917504;
    localparam logic [GAIN_W-1:0] RST_GAIN_I_X   = 24'd1311;
    localparam logic [GAIN_W-1:0] RST_GAIN_P_Y   = 24'd140902;
    localparam logic [GAIN_W-1:0] RST_GAIN_D_Y   = 24'd917504;
    localparam logic [GAIN_W-1:0] RST_GAIN_I_Y   = 24'd131;

    // Sample and pulse limits
    localparam logic [7:0]         LOST_MARK   = 8'd253;
    localparam logic [10:0]        CENTRE      = 11'd750;
    localparam logic [10:0]        PULSE_MIN   = 11'd400;
    localparam logic [10:0]        PULSE_MAX   = 11'd1100;
    localparam logic signed [8:0]  DEAD_BAND   = 9'sd5;
    localparam logic signed [49:0] CENTRE_Q17  = 50'sd98304000;

    // Integral limits, in half units
    localparam logic [9:0]         COUNT_LIMIT  = 10'd1000;
    localparam logic signed [23:0] TRIM_TRIGGER = 24'sd50000;
    localparam logic signed [23:0] TRIM_LEVEL   = 24'sd5000;
    localparam logic signed [25:0] INTEG_MAX    = 26'sd8388607;
    localparam logic signed [25:0] INTEG_MIN    = -26'sd8388608;

endpackage

@@ sv/two_axis_pid_servo_controller.sv @@
`timescale 1ns / 1ps
// ============================================================================
// two_axis_pid_servo_controller
// Per-axis PID on camera samples, giving servo compare values in 400..1100.
// ============================================================================
// The block takes one camera sample per clock while the output side is not
// stalled, and returns one pair of servo compare values per sample, in order.
// It is a four-register pipeline: the input register; the error, integral
// and step-counter update (the only loop, closed through the state registers
// alone, which is what lets samples follow back to back); the three gain
// multiplications per axis; and the sum, dead band and clamp into the output
// register. A sample of 253 on both axes returns 750 on both pulses with
// target_lost set and leaves the integrals, previous errors and step counter
// untouched. Gains and setpoints are to be written only while no sample is in
// flight.
// ============================================================================
module two_axis_pid_servo_controller (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // sample channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  tapsc_pkg::t_in_beat        i_in_beat,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output tapsc_pkg::t_out_beat       o_out_beat,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  tapsc_pkg::t_reg_idx        i_cfg_index,
    input  logic [tapsc_pkg::CFG_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Arithmetic helpers
    // ------------------------------------------------------------------
    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] r;
        if (v > tapsc_pkg::INTEG_MAX) begin
            r = tapsc_pkg::INTEG_MAX[23:0];
        end else if (v < tapsc_pkg::INTEG_MIN) begin
            r = tapsc_pkg::INTEG_MIN[23:0];
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [10:0] to_pulse(
        input logic signed [32:0] prod_p,
        input logic signed [33:0] prod_d,
        input logic signed [47:0] prod_i,
        input logic signed [8:0]  err
    );
        logic signed [49:0] acc;
        logic [32:0]        whole;
        logic [10:0]        r;
        acc = (50'(prod_p) <<< 1) + (50'(prod_d) <<< 1) + 50'(prod_i)
            + tapsc_pkg::CENTRE_Q17;
        whole = acc[49:17];
        if ((err > -tapsc_pkg::DEAD_BAND) && (err < tapsc_pkg::DEAD_BAND)) begin
            r = tapsc_pkg::CENTRE;
        end else if (acc[49]) begin
            r = tapsc_pkg::PULSE_MIN;
        end else if (whole > {22'd0, tapsc_pkg::PULSE_MAX}) begin
            r = tapsc_pkg::PULSE_MAX;
        end else if (whole < {22'd0, tapsc_pkg::PULSE_MIN}) begin
            r = tapsc_pkg::PULSE_MIN;
        end else begin
            r = whole[10:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [7:0]                    r_setpoint_x, r_setpoint_y;
    logic [tapsc_pkg::GAIN_W-1:0]  r_gain_p_x, r_gain_d_x, r_gain_i_x;
    logic [tapsc_pkg::GAIN_W-1:0]  r_gain_p_y, r_gain_d_y, r_gain_i_y;

    logic signed [23:0] r_integ_x, r_integ_y;
    logic signed [8:0]  r_last_err_x, r_last_err_y;
    logic [9:0]         r_step_count;

    logic                r_s1_valid;
    tapsc_pkg::t_in_beat r_s1_beat;

    logic               r_s2_valid, r_s2_lost;
    logic signed [8:0]  r_s2_err_x, r_s2_err_y;
    logic signed [9:0]  r_s2_diff_x, r_s2_diff_y;
    logic signed [23:0] r_s2_integ_x, r_s2_integ_y;

    logic               r_s3_valid, r_s3_lost;
    logic signed [8:0]  r_s3_err_x, r_s3_err_y;
    logic signed [32:0] r_s3_prod_p_x, r_s3_prod_p_y;
    logic signed [33:0] r_s3_prod_d_x, r_s3_prod_d_y;
    logic signed [47:0] r_s3_prod_i_x, r_s3_prod_i_y;

    logic                 r_out_valid;
    tapsc_pkg::t_out_beat r_out_beat;
    tapsc_pkg::t_out_beat n_out_beat;

    logic free_out, free3, free2, free1;

    logic               c_lost;
    logic signed [8:0]  c_err_x, c_err_y;
    logic signed [9:0]  c_diff_x, c_diff_y;
    logic signed [25:0] c_isum_x, c_isum_y;
    logic signed [23:0] c_integ_x, c_integ_y;
    logic [9:0]         c_cnt_inc;
    logic               c_trim;
    logic               c_update;

    logic signed [23:0] n_integ_x, n_integ_y;
    logic [9:0]         n_step_count;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when the stage after it is empty or moving
    // ------------------------------------------------------------------
    assign free_out   = !r_out_valid || i_out_ready;
    assign free3      = !r_s3_valid || free_out;
    assign free2      = !r_s2_valid || free3;
    assign free1      = !r_s1_valid || free2;
    assign o_in_ready = free1;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (free1) begin
                r_s1_valid <= i_in_valid;
            end
            if (free2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (free3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (free_out) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint_x <= tapsc_pkg::RST_SETPOINT_X;
            r_setpoint_y <= tapsc_pkg::RST_SETPOINT_Y;
            r_gain_p_x   <= tapsc_pkg::RST_GAIN_P_X;
            r_gain_d_x   <= tapsc_pkg::RST_GAIN_D_X;
            r_gain_i_x   <= tapsc_pkg::RST_GAIN_I_X;
            r_gain_p_y   <= tapsc_pkg::RST_GAIN_P_Y;
            r_gain_d_y   <= tapsc_pkg::RST_GAIN_D_Y;
            r_gain_i_y   <= tapsc_pkg::RST_GAIN_I_Y;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tapsc_pkg::REG_SETPOINT_X: r_setpoint_x <= i_cfg_data[7:0];
                tapsc_pkg::REG_SETPOINT_Y: r_setpoint_y <= i_cfg_data[7:0];
                tapsc_pkg::REG_GAIN_P_X:   r_gain_p_x   <= i_cfg_data;
                tapsc_pkg::REG_GAIN_D_X:   r_gain_d_x   <= i_cfg_data;
                tapsc_pkg::REG_GAIN_I_X:   r_gain_i_x   <= i_cfg_data;
                tapsc_pkg::REG_GAIN_P_Y:   r_gain_p_y   <= i_cfg_data;
                tapsc_pkg::REG_GAIN_D_Y:   r_gain_d_y   <= i_cfg_data;
                tapsc_pkg::REG_GAIN_I_Y:   r_gain_i_y   <= i_cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: hold the accepted sample beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_s1_beat <= i_in_beat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: errors, trapezoidal integral, step counter and trim
    // ------------------------------------------------------------------
    always_comb begin
        c_lost = (r_s1_beat.ball_x == tapsc_pkg::LOST_MARK)
              && (r_s1_beat.ball_y == tapsc_pkg::LOST_MARK);

        c_err_x = $signed({1'b0, r_setpoint_x}) - $signed({1'b0, r_s1_beat.ball_x});
        c_err_y = $signed({1'b0, r_s1_beat.ball_y}) - $signed({1'b0, r_setpoint_y});

        c_diff_x = 10'(c_err_x) - 10'(r_last_err_x);
        c_diff_y = 10'(c_err_y) - 10'(r_last_err_y);

        c_isum_x = 26'(r_integ_x) + 26'(r_last_err_x) + 26'(c_err_x);
        c_isum_y = 26'(r_integ_y) + 26'(r_last_err_y) + 26'(c_err_y);
        c_integ_x = sat24(c_isum_x);
        c_integ_y = sat24(c_isum_y);

        c_cnt_inc = r_step_count + 10'd1;
        c_trim = (c_cnt_inc >= tapsc_pkg::COUNT_LIMIT)
              || (c_integ_x > tapsc_pkg::TRIM_TRIGGER)
              || (c_integ_y > tapsc_pkg::TRIM_TRIGGER);

        n_integ_x    = c_integ_x;
        n_integ_y    = c_integ_y;
        n_step_count = c_cnt_inc;
        if (c_trim) begin
            n_step_count = '0;
            if (c_integ_x > tapsc_pkg::TRIM_LEVEL) begin
                n_integ_x = '0;
            end
            if (c_integ_y > tapsc_pkg::TRIM_LEVEL) begin
                n_integ_y = c_integ_y >>> 1;
            end
        end

        // a lost sample moves on but leaves the controller state alone
        c_update = r_s1_valid && free2 && !c_lost;
    end

    // Advance controller state once per tracked sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_x    <= '0;
            r_integ_y    <= '0;
            r_last_err_x <= '0;
            r_last_err_y <= '0;
            r_step_count <= '0;
        end else if (c_update) begin
            r_integ_x    <= n_integ_x;
            r_integ_y    <= n_integ_y;
            r_last_err_x <= c_err_x;
            r_last_err_y <= c_err_y;
            r_step_count <= n_step_count;
        end
    end

    // Stage 2: operands for the multipliers (integral before trim)
    always_ff @(posedge i_clk) begin
        if (free2) begin
            r_s2_lost    <= c_lost;
            r_s2_err_x   <= c_err_x;
            r_s2_err_y   <= c_err_y;
            r_s2_diff_x  <= c_diff_x;
            r_s2_diff_y  <= c_diff_y;
            r_s2_integ_x <= c_integ_x;
            r_s2_integ_y <= c_integ_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: gain products, one multiplier per term
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (free3) begin
            r_s3_lost     <= r_s2_lost;
            r_s3_err_x    <= r_s2_err_x;
            r_s3_err_y    <= r_s2_err_y;
            r_s3_prod_p_x <= 33'($signed({1'b0, r_gain_p_x})) * 33'(r_s2_err_x);
            r_s3_prod_p_y <= 33'($signed({1'b0, r_gain_p_y})) * 33'(r_s2_err_y);
            r_s3_prod_d_x <= 34'($signed({1'b0, r_gain_d_x})) * 34'(r_s2_diff_x);
            r_s3_prod_d_y <= 34'($signed({1'b0, r_gain_d_y})) * 34'(r_s2_diff_y);
            r_s3_prod_i_x <= 48'($signed({1'b0, r_gain_i_x})) * 48'(r_s2_integ_x);
            r_s3_prod_i_y <= 48'($signed({1'b0, r_gain_i_y})) * 48'(r_s2_integ_y);
        end
    end

    // ------------------------------------------------------------------
    // Output: sum the terms, apply dead band and clamp, or centre when lost
    // ------------------------------------------------------------------
    always_comb begin
        if (r_s3_lost) begin
            n_out_beat.pulse_x     = tapsc_pkg::CENTRE;
            n_out_beat.pulse_y     = tapsc_pkg::CENTRE;
            n_out_beat.target_lost = 1'b1;
        end else begin
            n_out_beat.pulse_x = to_pulse(r_s3_prod_p_x, r_s3_prod_d_x,
                                          r_s3_prod_i_x, r_s3_err_x);
            n_out_beat.pulse_y = to_pulse(r_s3_prod_p_y, r_s3_prod_d_y,
                                          r_s3_prod_i_y, r_s3_err_y);
            n_out_beat.target_lost = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_out) begin
            r_out_beat <= n_out_beat;
        end
    end

endmodule

@@ tb/sv/servo_pulse_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// servo_pulse_checker
// Watches the sample, result and register channels of the two-axis PID servo
// controller. It keeps its own copy of the setpoints, gains, integrals,
// previous errors and step counter. It works out the pulse pair for every
// sample beat and compares each result beat, field by field, with the oldest
// pulse pair still waiting.
// ============================================================================
module servo_pulse_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  tapsc_pkg::t_in_beat         i_in_beat,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  tapsc_pkg::t_out_beat        i_out_beat,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  tapsc_pkg::t_reg_idx         i_cfg_index,
    input  logic [tapsc_pkg::CFG_W-1:0] i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);
    import tapsc_pkg::*;

    // One unit of the Q17 drive value
    localparam longint Q17_ONE = 64'sd131072;

    logic [7:0]        sp_x, sp_y;
    logic [GAIN_W-1:0] kp_x, kd_x, ki_x, kp_y, kd_y, ki_y;
    int                integ_x, integ_y, prev_err_x, prev_err_y, step_cnt;
    t_out_beat         pulse_q [$];
    int                fails;

    // Saturate an integral to its 24-bit signed range
    function automatic int clip24(int v);
        if (v > int'(INTEG_MAX)) return int'(INTEG_MAX);
        if (v < int'(INTEG_MIN)) return int'(INTEG_MIN);
        return v;
    endfunction

    // Centre plus the three terms, in units of 2^-17
    function automatic longint drive_q17(int err, int prev, int integ,
                                         logic [GAIN_W-1:0] kp,
                                         logic [GAIN_W-1:0] kd,
                                         logic [GAIN_W-1:0] ki);
        return longint'(CENTRE) * Q17_ONE
             + 2 * longint'(kp) * err
             + 2 * longint'(kd) * (err - prev)
             + longint'(ki) * integ;
    endfunction

    // Dead band, truncation and clamp into the servo range
    function automatic logic [10:0] shape_pulse(longint drv, int err);
        longint whole;
        if (err > -int'(DEAD_BAND) && err < int'(DEAD_BAND)) return CENTRE;
        if (drv < 0) return PULSE_MIN;
        whole = drv / Q17_ONE;
        if (whole > longint'(PULSE_MAX)) return PULSE_MAX;
        if (whole < longint'(PULSE_MIN)) return PULSE_MIN;
        return whole[10:0];
    endfunction

    // Advance the controller state by one sample and give its pulse pair
    function automatic t_out_beat next_pulses(t_in_beat s);
        t_out_beat r;
        int        ex, ey;
        longint    dx, dy;
        r.target_lost = 1'b0;
        if (s.ball_x == LOST_MARK && s.ball_y == LOST_MARK) begin
            r.pulse_x     = CENTRE;
            r.pulse_y     = CENTRE;
            r.target_lost = 1'b1;
            return r;
        end
        ex = int'(sp_x) - int'(s.ball_x);
        ey = int'(s.ball_y) - int'(sp_y);
        integ_x = clip24(integ_x + prev_err_x + ex);
        integ_y = clip24(integ_y + prev_err_y + ey);
        dx = drive_q17(ex, prev_err_x, integ_x, kp_x, kd_x, ki_x);
        dy = drive_q17(ey, prev_err_y, integ_y, kp_y, kd_y, ki_y);
        prev_err_x = ex;
        prev_err_y = ey;
        // trim the integrals when the count reaches its limit or on a large sum; pulses use the untrimmed ones
        step_cnt = (step_cnt + 1) % 1024;
        if (step_cnt >= int'(COUNT_LIMIT) || integ_x > int'(TRIM_TRIGGER) ||
            integ_y > int'(TRIM_TRIGGER)) begin
            step_cnt = 0;
            if (integ_x > int'(TRIM_LEVEL)) integ_x = 0;
            if (integ_y > int'(TRIM_LEVEL)) integ_y = integ_y >>> 1;
        end
        r.pulse_x = shape_pulse(dx, ex);
        r.pulse_y = shape_pulse(dy, ey);
        return r;
    endfunction

    // Track register writes, predict on sample beats, compare on result beats
    always @(posedge i_clk) begin : watch
        t_out_beat want;
        if (!i_rst_n) begin
            sp_x       = RST_SETPOINT_X;
            sp_y       = RST_SETPOINT_Y;
            kp_x       = RST_GAIN_P_X;
            kd_x       = RST_GAIN_D_X;
            ki_x       = RST_GAIN_I_X;
            kp_y       = RST_GAIN_P_Y;
            kd_y       = RST_GAIN_D_Y;
            ki_y       = RST_GAIN_I_Y;
            integ_x    = 0;
            integ_y    = 0;
            prev_err_x = 0;
            prev_err_y = 0;
            step_cnt   = 0;
            fails      = 0;
            pulse_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SETPOINT_X: sp_x = i_cfg_data[7:0];
                    REG_SETPOINT_Y: sp_y = i_cfg_data[7:0];
                    REG_GAIN_P_X:   kp_x = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_D_X:   kd_x = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_I_X:   ki_x = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_P_Y:   kp_y = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_D_Y:   kd_y = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_I_Y:   ki_y = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pulse_q.size() == 0) begin
                    $error("result beat with no sample waiting: pulse_x %0d pulse_y %0d lost %0b",
                           i_out_beat.pulse_x, i_out_beat.pulse_y, i_out_beat.target_lost);
                    fails++;
                end else begin
                    want = pulse_q.pop_front();
                    if (i_out_beat.pulse_x !== want.pulse_x) begin
                        $error("pulse_x: expected %0d, got %0d",
                               want.pulse_x, i_out_beat.pulse_x);
                        fails++;
                    end
                    if (i_out_beat.pulse_y !== want.pulse_y) begin
                        $error("pulse_y: expected %0d, got %0d",
                               want.pulse_y, i_out_beat.pulse_y);
                        fails++;
                    end
                    if (i_out_beat.target_lost !== want.target_lost) begin
                        $error("target_lost: expected %0b, got %0b",
                               want.target_lost, i_out_beat.target_lost);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) pulse_q.push_back(next_pulses(i_in_beat));
        end
        o_fail_count <= fails;
        o_pending    <= pulse_q.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives camera samples and register writes into the two-axis PID servo
// controller under random idling and back-pressure. Phases cover directed
// corner samples, random and extreme settings, a long output stall, small
// errors around the dead band, large-sum trims and a closing stretch of large
// negative errors. Checking is done by the pulse checker beside the block.
// ============================================================================
module testbench;
    import tapsc_pkg::*;

    localparam int NREGS        = 8;
    localparam int LONG_HOLD    = 80;
    localparam int SMALL_RUN    = 30;
    localparam int TRIM_RUN     = 160;
    localparam int NEG_RUN      = 20;
    localparam int LIMIT_CYCLES = 400000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in_beat         in_beat   = '0;
    logic             in_ready;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_beat        out_beat;
    logic             cfg_valid = 1'b0;
    t_reg_idx         cfg_index = REG_SETPOINT_X;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             cfg_ready;
    int               fail_count;
    int               pending;
    bit               idle_on     = 1'b1;
    bit               rx_hold_req = 1'b0;
    logic [CFG_W-1:0] cfg_set [NREGS];
    logic [7:0]       sp_x        = RST_SETPOINT_X;
    logic [7:0]       sp_y        = RST_SETPOINT_Y;
    int               cycles      = 0;

    two_axis_pid_servo_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    servo_pulse_checker pulse_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_beat    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_beat   (out_beat),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: long hold on request, otherwise short random stalls
    initial begin : result_sink
        int n;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                out_ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
                rx_hold_req = 1'b0;
                out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one sample beat and hold it until accepted
    task automatic send_sample(input logic [7:0] bx, input logic [7:0] by);
        t_in_beat s;
        s.ball_x = bx;
        s.ball_y = by;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every pulse pair has come back
    task automatic wait_drained;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    // Write all registers from cfg_set, one beat each
    task automatic program_regs;
        int i;
        for (i = 0; i < NREGS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= t_reg_idx'(i);
            cfg_data  <= cfg_set[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        sp_x = cfg_set[REG_SETPOINT_X][7:0];
        sp_y = cfg_set[REG_SETPOINT_Y][7:0];
    endtask

    // Random settings: mostly moderate gains, some across the full width
    task automatic shuffle_settings;
        int i;
        for (i = 0; i < NREGS; i++) begin
            if ($urandom_range(0, 3) == 0) cfg_set[i] = CFG_W'($urandom());
            else cfg_set[i] = CFG_W'($urandom_range(0, 1 << 20));
        end
    endtask

    task automatic fill_settings(input logic [7:0] sx, input logic [7:0] sy,
                                 input logic [CFG_W-1:0] gain);
        int i;
        for (i = REG_GAIN_P_X; i < NREGS; i++) cfg_set[i] = gain;
        cfg_set[REG_SETPOINT_X] = CFG_W'(sx);
        cfg_set[REG_SETPOINT_Y] = CFG_W'(sy);
    endtask

    // Mostly a ball wandering near the setpoint, some noise, a few lost frames
    function automatic t_in_beat random_sample();
        t_in_beat s;
        int       pick, vx, vy;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            s.ball_x = LOST_MARK;
            s.ball_y = LOST_MARK;
        end else if (pick < 30) begin
            s.ball_x = 8'($urandom());
            s.ball_y = 8'($urandom());
        end else begin
            vx = int'(sp_x) + int'($urandom_range(0, 30)) - 15;
            vy = int'(sp_y) + int'($urandom_range(0, 30)) - 15;
            vx = (vx < 0) ? 0 : (vx > 255) ? 255 : vx;
            vy = (vy < 0) ? 0 : (vy > 255) ? 255 : vy;
            s.ball_x = 8'(vx);
            s.ball_y = 8'(vy);
        end
        return s;
    endfunction

    task automatic run_mixed(input int count);
        int       i;
        t_in_beat s;
        for (i = 0; i < count; i++) begin
            s = random_sample();
            send_sample(s.ball_x, s.ball_y);
        end
    endtask

    initial begin : stimulus
        int i, e;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner samples under reset settings: zero error, extremes, lost
        // marker and its near misses, both edges of the dead band
        send_sample(8'd80, 8'd60);
        send_sample(8'd0, 8'd0);
        send_sample(8'd255, 8'd255);
        send_sample(8'd0, 8'd255);
        send_sample(8'd255, 8'd0);
        send_sample(LOST_MARK, LOST_MARK);
        send_sample(LOST_MARK, 8'd0);
        send_sample(8'd0, LOST_MARK);
        send_sample(8'd76, 8'd64);
        send_sample(8'd84, 8'd56);
        send_sample(8'd75, 8'd65);
        send_sample(8'd85, 8'd55);
        send_sample(LOST_MARK, LOST_MARK);
        send_sample(8'd80, 8'd60);
        send_sample(8'd128, 8'd128);
        send_sample(8'd1, 8'd254);
        send_sample(8'd254, 8'd1);
        wait_drained();

        // Every register at random, then a mixed stream
        shuffle_settings();
        program_regs();
        run_mixed(40);
        wait_drained();

        // Gains at both extremes, setpoints at opposite corners
        fill_settings(8'd0, 8'd255, {CFG_W{1'b1}});
        program_regs();
        run_mixed(20);
        wait_drained();
        fill_settings(8'd255, 8'd0, '0);
        program_regs();
        run_mixed(20);
        wait_drained();

        // Hold the result side for a long stretch while samples keep coming
        shuffle_settings();
        program_regs();
        rx_hold_req = 1'b1;
        run_mixed(40);
        wait_drained();

        // Small positive errors on both sides of the dead band
        shuffle_settings();
        cfg_set[REG_SETPOINT_X] = CFG_W'(RST_SETPOINT_X);
        cfg_set[REG_SETPOINT_Y] = CFG_W'(RST_SETPOINT_Y);
        program_regs();
        for (i = 0; i < SMALL_RUN; i++) begin
            idle_on = (i < SMALL_RUN / 2);
            e = $urandom_range(2, 15);
            if ($urandom_range(0, 49) == 0) send_sample(LOST_MARK, LOST_MARK);
            else send_sample(8'(int'(sp_x) - e), 8'(int'(sp_y) + e));
        end
        idle_on = 1'b1;
        wait_drained();

        // Large positive errors to force sum trims, then random non-negative ones
        shuffle_settings();
        cfg_set[REG_SETPOINT_X] = CFG_W'(8'd255);
        cfg_set[REG_SETPOINT_Y] = '0;
        program_regs();
        for (i = 0; i < TRIM_RUN; i++)
            send_sample(8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)));
        for (i = 0; i < 20; i++)
            send_sample(8'($urandom()), 8'($urandom_range(0, 127)));
        wait_drained();

        // Random settings and mixed traffic
        for (i = 0; i < 2; i++) begin
            shuffle_settings();
            program_regs();
            run_mixed(10);
            wait_drained();
        end

        // No idling from here: large negative errors back to back
        idle_on = 1'b0;
        shuffle_settings();
        cfg_set[REG_SETPOINT_X] = '0;
        cfg_set[REG_SETPOINT_Y] = CFG_W'(8'd255);
        program_regs();
        for (i = 0; i < NEG_RUN; i++) begin
            if ($urandom_range(0, 9) == 0) send_sample(LOST_MARK, LOST_MARK);
            else send_sample(8'd255, 8'd0);
        end
        run_mixed(20);
        wait_drained();

        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
